>>> hw/rtl/clt_pkg.sv
// clt_pkg: types and constants of the command line tokenizer
// beat payloads, request and event codes, character codes, queue entry
// no dependencies
package clt_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CHAR  = 3'd1,
    EV_ARG   = 3'd2,
    EV_CMD   = 3'd3,
    EV_ERR   = 3'd4,
    EV_READ  = 3'd5,
    EV_CLEAR = 3'd6
  } event_e;

  // character codes
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_EOT       = 8'h04;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

  // widest row and position fields the queue entry has to carry
  localparam int unsigned ROW_QW = 4;
  localparam int unsigned POS_QW = 6;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PW    = 1;
  localparam int unsigned Q_CW    = 2;

  // store operation handed to the back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_in;
    logic [2:0] read_arg;
    logic [3:0] read_pos;
  } in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] arg_total;
    logic [4:0] char_index;
    logic       command_ready;
    logic [7:0] read_byte;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [ROW_QW-1:0] row;
    logic [POS_QW-1:0] pos;
    logic [7:0]        data;
    event_e            ev;
    logic [3:0]        arg_total;
    logic [4:0]        char_index;
    logic              command_ready;
  } q_entry_t;

endpackage

>>> hw/rtl/clt_front.sv
// clt_front: parser front end of the command line tokenizer
// classifies each accepted beat, keeps the parse state, issues store operations
// depends on clt_pkg
module clt_front import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_t      in_data_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o,
  input  logic     q_full_i
);

  localparam int unsigned CW = $clog2(MAX_ARGS + 1);
  localparam int unsigned LW = $clog2(MAX_ARG_LEN + 1);

  typedef enum logic [1:0] {
    CLS_LIT   = 2'd0,
    CLS_WS    = 2'd1,
    CLS_MINUS = 2'd2,
    CLS_END   = 2'd3
  } cls_e;

  logic          esc_q, esc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] pos_q, pos_d;
  logic          rdy_q, rdy_d;
  logic          fire;
  cls_e          cls;
  logic          do_store;
  logic          wipe;
  op_e           op;
  event_e        ev;

  assign in_stall_o = q_full_i;
  assign fire       = in_valid_i & ~q_full_i;
  assign q_push_o   = fire;

  // character class
  always_comb begin
    priority if (in_data_i.char_in == CH_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_data_i.char_in == CH_SPACE || in_data_i.char_in == CH_TAB) begin
      cls = CLS_WS;
    end else if (in_data_i.char_in == CH_CR || in_data_i.char_in == CH_LF ||
                 in_data_i.char_in == CH_NUL || in_data_i.char_in == CH_EOT) begin
      cls = CLS_END;
    end else begin
      cls = CLS_LIT;
    end
  end

  // next parse state and store operation
  always_comb begin
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    rdy_d    = rdy_q;
    op       = OP_NONE;
    ev       = EV_NONE;
    do_store = 1'b0;
    wipe     = 1'b0;
    unique case (in_data_i.req_type)
      REQ_CHAR: begin
        if (in_data_i.char_in > CH_ASCII_MAX) begin
          wipe = 1'b1;
          ev   = EV_ERR;
        end else if (esc_q) begin
          esc_d    = 1'b0;
          do_store = 1'b1;
        end else begin
          unique case (cls)
            CLS_MINUS: esc_d = 1'b1;
            CLS_WS: begin
              if (cnt_q < CW'(MAX_ARGS)) begin
                cnt_d = cnt_q + CW'(1);
                pos_d = '0;
                ev    = EV_ARG;
              end else begin
                wipe = 1'b1;
                ev   = EV_ERR;
              end
            end
            CLS_END: begin
              rdy_d = 1'b1;
              ev    = EV_CMD;
            end
            default: do_store = 1'b1;
          endcase
        end
        // literal or escaped byte goes to the current argument
        if (do_store) begin
          if (pos_q < LW'(MAX_ARG_LEN)) begin
            op    = OP_WRITE;
            pos_d = pos_q + LW'(1);
            ev    = EV_CHAR;
          end else begin
            wipe = 1'b1;
            ev   = EV_ERR;
          end
        end
      end
      REQ_READ: begin
        ev = EV_READ;
        if (32'(in_data_i.read_arg) < MAX_ARGS && 32'(in_data_i.read_pos) < MAX_ARG_LEN) begin
          op = OP_READ;
        end
      end
      REQ_CLEAR: begin
        wipe = 1'b1;
        ev   = EV_CLEAR;
      end
      default: ev = EV_NONE;
    endcase
    // error or clear returns everything to reset values
    if (wipe) begin
      esc_d = 1'b0;
      cnt_d = CW'(1);
      pos_d = '0;
      rdy_d = 1'b0;
      op    = OP_CLEAR;
    end
  end

  // queue entry
  always_comb begin
    q_entry_o.op            = op;
    q_entry_o.row           = (op == OP_READ) ? ROW_QW'(in_data_i.read_arg)
                                              : ROW_QW'(cnt_q - CW'(1));
    q_entry_o.pos           = (op == OP_READ) ? POS_QW'(in_data_i.read_pos)
                                              : POS_QW'(pos_q);
    q_entry_o.data          = in_data_i.char_in;
    q_entry_o.ev            = ev;
    q_entry_o.arg_total     = 4'(cnt_d);
    q_entry_o.char_index    = 5'(pos_d);
    q_entry_o.command_ready = rdy_d;
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= CW'(1);
      pos_q <= '0;
      rdy_q <= 1'b0;
    end else if (fire) begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      rdy_q <= rdy_d;
    end
  end

  // checks on the parse state
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CW'(MAX_ARGS) && pos_q <= LW'(MAX_ARG_LEN))
    else $error("argument count or position out of range");

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_data_i.req_type == REQ_CLEAR |=>
      cnt_q == CW'(1) && pos_q == '0 && !rdy_q && !esc_q)
    else $error("clear did not return parser to reset state");

  // a character beat always ends a pending escape
  a_escape_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && esc_q && in_data_i.req_type == REQ_CHAR |=> !esc_q)
    else $error("escape outlived the escaped beat");

  a_high_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_data_i.req_type == REQ_CHAR && in_data_i.char_in > CH_ASCII_MAX |->
      q_entry_o.op == OP_CLEAR && q_entry_o.ev == EV_ERR)
    else $error("byte above ascii range not treated as error");

endmodule

>>> hw/rtl/clt_queue.sv
// clt_queue: short queue of store operations between front and back
// decouples the parser from the store and output stall
// depends on clt_pkg
module clt_queue import clt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     valid_o,
  output q_entry_t entry_o,
  input  logic     pop_i
);

  q_entry_t            entries_q [Q_DEPTH];
  logic [Q_PW-1:0]     wr_q, wr_d;
  logic [Q_PW-1:0]     rd_q, rd_d;
  logic [Q_CW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CW'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = entries_q[rd_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/clt_back.sv
// clt_back: argument store and result output of the command line tokenizer
// carries out queued store operations and registers each result beat
// depends on clt_pkg
module clt_back import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_entry_t q_entry_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_t     out_data_o
);

  localparam int unsigned RW    = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int unsigned PW    = (MAX_ARG_LEN > 1) ? $clog2(MAX_ARG_LEN) : 1;
  localparam int unsigned LW    = $clog2(MAX_ARG_LEN + 1);
  localparam int unsigned NR    = 2 ** RW;
  localparam int unsigned DEPTH = 2 ** (RW + PW);

  logic [7:0]       mem_q [DEPTH];
  logic [LW-1:0]    fill_q [NR];
  logic [RW-1:0]    rrow;
  logic [PW-1:0]    rpos;
  logic [RW+PW-1:0] addr;
  logic             hit;
  logic [7:0]       rdata_q;
  logic             s1_valid_q;
  q_entry_t         s1_q;
  logic             s1_hit_q;
  logic             out_valid_q;
  out_t             out_q;
  logic             out_free, s1_move, s1_free, pop;

  // handshake between stages
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign s1_move  = s1_valid_q & out_free;
  assign s1_free  = ~s1_valid_q | s1_move;
  assign pop      = q_valid_i & s1_free;
  assign q_pop_o  = pop;

  // store address; a byte is valid only below its row's fill count
  assign rrow = q_entry_i.row[RW-1:0];
  assign rpos = q_entry_i.pos[PW-1:0];
  assign addr = {rrow, rpos};
  assign hit  = {1'b0, q_entry_i.pos} < (POS_QW + 1)'(fill_q[rrow]);

  // argument store, registered read
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rdata_q <= mem_q[addr];
      if (q_entry_i.op == OP_WRITE) begin
        mem_q[addr] <= q_entry_i.data;
      end
    end
  end

  // per-row fill counts, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NR; i++) begin
        fill_q[i] <= '0;
      end
    end else if (pop) begin
      if (q_entry_i.op == OP_CLEAR) begin
        for (int i = 0; i < NR; i++) begin
          fill_q[i] <= '0;
        end
      end else if (q_entry_i.op == OP_WRITE) begin
        fill_q[rrow] <= LW'(q_entry_i.pos) + LW'(1);
      end
    end
  end

  // access stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q     <= q_entry_i;
      s1_hit_q <= hit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.event_kind    <= s1_q.ev;
      out_q.arg_total     <= s1_q.arg_total;
      out_q.char_index    <= s1_q.char_index;
      out_q.command_ready <= s1_q.command_ready;
      out_q.read_byte     <= (s1_q.op == OP_READ && s1_hit_q) ? rdata_q : 8'h00;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/command_line_tokenizer.sv
// command_line_tokenizer: top level of the command line tokenizer
// joins parser front end, operation queue and store back end
// depends on clt_pkg, clt_front, clt_queue, clt_back
//
// Splits a byte stream into up to MAX_ARGS arguments of up to MAX_ARG_LEN
// bytes, answers read-back and clear requests, and returns one result beat
// for every accepted input beat, in order. One beat is taken per clock while
// the queue is not full: the parse state is computed and registered in the front end,
// and the back end does one store write or read per cycle on a single-port array
// while its access stage can move on. A result passes the queue, the access stage
// and the output register before it is presented; a two-entry queue lets input
// carry on while the output is held. The store is cleared at once, when an error
// or clear request reaches the back end, by per-argument fill counts, so there is
// no clearing pass after reset.
module command_line_tokenizer import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic     push, full, q_valid, pop;
  q_entry_t push_entry, pop_entry;

  // parser front end
  clt_front #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_push_o   (push),
    .q_entry_o  (push_entry),
    .q_full_i   (full)
  );

  // operation queue
  clt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .pop_i   (pop)
  );

  // store and output back end
  clt_back #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/clt_checker.sv
// clt_checker: watches both beat channels of the command line tokenizer,
// predicts each result from its own parser state and compares field by field
// depends on clt_pkg
`timescale 1ns / 1ps

module clt_checker import clt_pkg::*; #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned err_resets_o,
  output int unsigned commands_o
);

  // parser state as the block should hold it
  bit          escape_q;
  int unsigned args_q;
  int unsigned pos_q;
  bit          ready_q;
  logic [7:0]  arg_bytes [MAX_ARGS*MAX_ARG_LEN];

  // results still owed by the block, oldest first
  out_t        owed_results [$];
  out_t        want;

  // back to the state after reset, store emptied
  function automatic void wipe_parser();
    escape_q = 1'b0;
    args_q   = 1;
    pos_q    = 0;
    ready_q  = 1'b0;
    foreach (arg_bytes[i]) arg_bytes[i] = 8'h00;
  endfunction

  // one input beat through the parser, returns the result it should give
  function automatic out_t parse_beat(input in_t beat);
    out_t       res;
    event_e     ev;
    logic [7:0] c;
    logic [7:0] rb;
    bit         keep_byte;
    ev        = EV_NONE;
    c         = beat.char_in;
    rb        = 8'h00;
    keep_byte = 1'b0;
    case (beat.req_type)
      REQ_CHAR: begin
        if (c > CH_ASCII_MAX) begin
          // non-ascii byte wins even over a pending escape
          wipe_parser();
          ev = EV_ERR;
        end else if (escape_q) begin
          escape_q  = 1'b0;
          keep_byte = 1'b1;
        end else if (c == CH_MINUS) begin
          escape_q = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          if (args_q < MAX_ARGS) begin
            args_q++;
            pos_q = 0;
            ev    = EV_ARG;
          end else begin
            wipe_parser();
            ev = EV_ERR;
          end
        end else if (c == CH_CR || c == CH_LF || c == CH_NUL || c == CH_EOT) begin
          ready_q = 1'b1;
          ev      = EV_CMD;
        end else begin
          keep_byte = 1'b1;
        end
        // literal or escaped byte goes into the current argument
        if (keep_byte) begin
          if (pos_q < MAX_ARG_LEN) begin
            arg_bytes[(args_q - 1) * MAX_ARG_LEN + pos_q] = c;
            pos_q++;
            ev = EV_CHAR;
          end else begin
            wipe_parser();
            ev = EV_ERR;
          end
        end
      end
      REQ_READ: begin
        ev = EV_READ;
        if (beat.read_arg < MAX_ARGS && beat.read_pos < MAX_ARG_LEN)
          rb = arg_bytes[beat.read_arg * MAX_ARG_LEN + beat.read_pos];
      end
      REQ_CLEAR: begin
        wipe_parser();
        ev = EV_CLEAR;
      end
      default: ;
    endcase
    res.event_kind    = ev;
    res.arg_total     = 4'(args_q);
    res.char_index    = 5'(pos_q);
    res.command_ready = ready_q;
    res.read_byte     = rb;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // accepted beats on both channels, sampled at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_parser();
      owed_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      err_resets_o = 0;
      commands_o   = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want = parse_beat(in_data_i);
        if (want.event_kind == EV_ERR) err_resets_o++;
        if (want.event_kind == EV_CMD) commands_o++;
        owed_results.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          check_field("event_kind", want.event_kind, out_data_i.event_kind);
          check_field("arg_total", want.arg_total, out_data_i.arg_total);
          check_field("char_index", want.char_index, out_data_i.char_index);
          check_field("command_ready", want.command_ready, out_data_i.command_ready);
          check_field("read_byte", want.read_byte, out_data_i.read_byte);
          checked_o++;
        end
      end
      pending_o = owed_results.size();
    end
  end

endmodule

>>> tb/tb_command_line_tokenizer.sv
// tb_command_line_tokenizer: stimulus and verdict for the command line tokenizer
// drives directed then random character lines; depends on clt_pkg,
// command_line_tokenizer and clt_checker
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
  import clt_pkg::*;

  localparam int unsigned MAX_ARGS    = 8;
  localparam int unsigned MAX_ARG_LEN = 16;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 64;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;
  int unsigned err_resets;
  int unsigned commands;

  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  bit          hold_done;

  command_line_tokenizer #(
    .MAX_ARGS   (MAX_ARGS),
    .MAX_ARG_LEN(MAX_ARG_LEN)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  clt_checker #(
    .MAX_ARGS   (MAX_ARGS),
    .MAX_ARG_LEN(MAX_ARG_LEN)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fails),
    .pending_o   (pending),
    .checked_o   (checked),
    .err_resets_o(err_resets),
    .commands_o  (commands)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("command_line_tokenizer test failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end else begin
        @(negedge clk);
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // beat builders, unused fields filled at random
  function automatic in_t char_beat(input logic [7:0] c);
    in_t b;
    b          = in_t'(17'($urandom));
    b.req_type = REQ_CHAR;
    b.char_in  = c;
    return b;
  endfunction

  function automatic in_t read_beat(input int unsigned arg, input int unsigned pos);
    in_t b;
    b          = in_t'(17'($urandom));
    b.req_type = REQ_READ;
    b.read_arg = 3'(arg);
    b.read_pos = 4'(pos);
    return b;
  endfunction

  function automatic in_t ctrl_beat(input logic [1:0] req);
    in_t b;
    b          = in_t'(17'($urandom));
    b.req_type = req;
    return b;
  endfunction

  // plain literal: printable or control, never a separator, minus or line end
  function automatic logic [7:0] literal_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 127));
    while (c == CH_MINUS || c == CH_SPACE || c == CH_TAB || c == CH_CR ||
           c == CH_LF || c == CH_EOT);
    return c;
  endfunction

  // byte following a minus: any class, now and then a non-ascii one
  function automatic logic [7:0] escaped_byte();
    case ($urandom_range(7))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_MINUS;
      3: return CH_CR;
      4: return CH_LF;
      5: return ($urandom_range(1)) ? CH_NUL : CH_EOT;
      6: return literal_byte();
      default: return ($urandom_range(5) == 0) ? 8'($urandom_range(128, 255)) :
                                                 literal_byte();
    endcase
  endfunction

  function automatic logic [7:0] line_end_byte();
    case ($urandom_range(3))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_NUL;
      default: return CH_EOT;
    endcase
  endfunction

  // offer one beat at the falling edge, hold it until taken
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // one command line: words, separators, escapes, line end, then read-back and at times a clear
  task automatic send_line();
    int unsigned nargs;
    int unsigned len;
    int unsigned r;
    int unsigned top_arg;
    nargs = $urandom_range(1, MAX_ARGS + 1);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) begin
        send_beat(char_beat(($urandom_range(1)) ? CH_SPACE : CH_TAB));
        if ($urandom_range(9) == 0) send_beat(char_beat(CH_SPACE));
      end
      r   = $urandom_range(19);
      len = (r == 0) ? MAX_ARG_LEN + 1 : (r == 1) ? MAX_ARG_LEN : $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          send_beat(char_beat(CH_MINUS));
          send_beat(char_beat(escaped_byte()));
        end else begin
          send_beat(char_beat(literal_byte()));
        end
      end
    end
    send_beat(char_beat(line_end_byte()));
    top_arg = (nargs > MAX_ARGS) ? MAX_ARGS - 1 : nargs - 1;
    repeat ($urandom_range(0, 4))
      send_beat(read_beat($urandom_range(0, top_arg),
                          ($urandom_range(3) == 0) ? $urandom_range(0, 15) :
                                                     $urandom_range(0, 7)));
    if ($urandom_range(2) == 0) send_beat(ctrl_beat(REQ_CLEAR));
  endtask

  // mostly well-formed lines, the rest fully random beats
  task automatic run_random(input int unsigned upto);
    while (items_sent < upto) begin
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 3)) send_beat(in_t'(17'($urandom)));
      else
        send_line();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    items_sent    = 0;
    hold_req      = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 46;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: literals at the ascii ends, both separators, escapes of a
    // separator, a minus and a line end, each line end, characters after a completed command
    send_beat(char_beat(8'h41));
    send_beat(char_beat(CH_ASCII_MAX));
    send_beat(char_beat(8'h01));
    send_beat(char_beat(CH_SPACE));
    send_beat(char_beat(CH_TAB));
    send_beat(char_beat(CH_MINUS));
    send_beat(char_beat(CH_SPACE));
    send_beat(char_beat(CH_MINUS));
    send_beat(char_beat(CH_MINUS));
    send_beat(char_beat(CH_MINUS));
    send_beat(char_beat(CH_CR));
    send_beat(char_beat(CH_LF));
    send_beat(char_beat(8'h62));
    send_beat(char_beat(CH_NUL));
    send_beat(char_beat(CH_EOT));
    send_beat(char_beat(CH_CR));
    // read-back of written and never written bytes
    send_beat(read_beat(0, 0));
    send_beat(read_beat(2, 2));
    send_beat(read_beat(MAX_ARGS - 1, MAX_ARG_LEN - 1));
    // non-ascii after a minus, then plain top byte
    send_beat(char_beat(CH_MINUS));
    send_beat(char_beat(8'h80));
    send_beat(char_beat(8'hFF));
    // unused request, clear, read after clear
    send_beat(ctrl_beat(REQ_UNUSED));
    send_beat(ctrl_beat(REQ_CLEAR));
    send_beat(read_beat(0, 0));

    // random lines under three idling patterns
    run_random(500);
    send_idle_pct = 46;
    recv_idle_pct = 10;
    run_random(1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(1500);

    // drain
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("%0d beats sent, %0d results checked", items_sent, checked);
    $display("%0d error resets and %0d completed commands, long output hold-off done: %0d",
             err_resets, commands, hold_done);
    if (fails == 0) begin
      $display("command_line_tokenizer test passed");
    end else begin
      $display("command_line_tokenizer test failed");
    end
    $finish;
  end

endmodule

>>> command_line_tokenizer.f
hw/rtl/clt_pkg.sv
hw/rtl/clt_front.sv
hw/rtl/clt_queue.sv
hw/rtl/clt_back.sv
hw/rtl/command_line_tokenizer.sv
tb/clt_checker.sv
tb/tb_command_line_tokenizer.sv
